/* rtl/assert_macros.svh */
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define CHK_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("check failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("check failed");

`endif

/* rtl/oaht_pkg.sv */
`timescale 1ns / 1ps
package oaht_pkg;
   localparam logic [1:0] CMD_LOOKUP = 2'd0;
   localparam logic [1:0] CMD_INSERT = 2'd1;
   localparam logic [1:0] CMD_REMOVE = 2'd2;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_NOT_FOUND  = 3'd1;
   localparam logic [2:0] ST_DUPLICATE  = 3'd2;
   localparam logic [2:0] ST_FULL       = 3'd3;
   localparam logic [2:0] ST_TOO_LONG   = 3'd4;
   localparam logic [2:0] ST_ZERO_VALUE = 3'd5;

   // Per-byte mixing step of the one-at-a-time hash.
   function automatic logic [31:0] oat_byte(input logic [31:0] h, input logic [7:0] b);
      logic [31:0] t;
      t = h + {24'd0, b};
      t = t + (t << 10);
      t = t ^ (t >> 6);
      return t;
   endfunction
endpackage

/* rtl/oaht_mod.sv */
`timescale 1ns / 1ps
// Sequential remainder: one restoring step per cycle.
module oaht_mod #(
   parameter int DW = 32,
   parameter int NW = 13
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [NW-1:0] divisor,
   output logic          done,
   output logic [NW-1:0] remainder
);
   localparam int CW = $clog2(DW + 1);
   logic [DW-1:0] q_ff, q_in;
   logic [NW:0]   r_ff, r_in;
   logic [NW-1:0] d_ff, d_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          run_ff, run_in, done_ff, done_in;
   logic [NW:0]   sh;

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; cnt_in = cnt_ff;
      run_in = run_ff; done_in = 1'b0;
      sh = {r_ff[NW-1:0], q_ff[DW-1]};
      if (start) begin
         q_in = dividend; r_in = '0; d_in = divisor;
         cnt_in = CW'(DW); run_in = 1'b1;
      end else if (run_ff) begin
         // shift in one bit, subtract when it fits
         q_in = q_ff << 1;
         r_in = (sh >= {1'b0, d_ff}) ? sh - {1'b0, d_ff} : sh;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            run_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in; cnt_ff <= cnt_in;
      if (reset) begin
         run_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         run_ff <= run_in; done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign remainder = r_ff[NW-1:0];
endmodule

/* rtl/open_addressing_hash_table_top.sv */
`timescale 1ns / 1ps
// Linear-probing key/value table with a one-at-a-time hash. Key bytes are taken
// one per cycle while busy is low; a byte without key_last leaves busy low. On
// the last byte the block goes busy. It finishes the hash in S_FIN, launches the
// remainder in S_FINW and waits in S_MOD for the serial remainder by the active
// bucket count. Then comes the probe walk: it visits buckets in turn and, in a
// bucket whose stored length matches, compares the key byte by byte; the walk
// ends without a match once every active bucket has been visited. An insert
// then walks for a free bucket (and reports full when there is none), and
// copies the key into it byte by byte. S_DONE emits the result. The result is
// on the rsp_ ports for one cycle, marked by rsp_valid. The receiver cannot
// stall it, and busy falls in that same cycle. An overlong key or a zero insert
// value skips the walk. Reset clears the bucket valid bits at once.
module open_addressing_hash_table_top #(
   parameter int BUCKETS       = 64,
   parameter int MAX_KEY_BYTES = 16,
   parameter int VALUE_BITS    = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_key_byte,
   input  logic        req_key_last,
   input  logic [31:0] req_value,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_found_value,
   output logic [6:0]  rsp_entry_count,
   input  logic        csr_we,
   input  logic [6:0]  csr_wdata
);
   import oaht_pkg::*;

   localparam int BW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int NW  = $clog2(BUCKETS + 1);
   localparam int KW  = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
   localparam int LW  = $clog2(MAX_KEY_BYTES + 1);
   localparam int VW  = (VALUE_BITS < 32) ? VALUE_BITS : 32;

   localparam logic [3:0] S_IDLE = 4'd0, S_FIN = 4'd1, S_MOD = 4'd2, S_CHK = 4'd3,
                          S_RD = 4'd4, S_CMP = 4'd5, S_FREE = 4'd6, S_DONE = 4'd7,
                          S_FINW = 4'd8;

   logic [3:0]    state_ff, state_in;
   logic [6:0]    bcnt_ff;
   logic [7:0]    kbuf [MAX_KEY_BYTES];
   logic [LW-1:0] klen_ff, klen_in;
   logic          kov_ff, kov_in;
   logic [31:0]   hash_ff, hash_in;
   logic [1:0]    fin_ff, fin_in;
   logic [1:0]    cmd_ff, cmd_in;
   logic [VW-1:0] val_ff, val_in;
   logic [BUCKETS-1:0] used_ff, used_in;
   logic [NW-1:0] cnt_ff, cnt_in;
   logic [NW-1:0] n_ff, n_in;
   logic [BW-1:0] b_ff, b_in, start_b_ff, start_b_in;
   logic [NW-1:0] k_ff, k_in;
   logic [KW-1:0] j_ff, j_in;
   logic [2:0]    st_ff, st_in;
   logic [31:0]   fv_ff, fv_in;
   logic          rv_ff, rv_in, mod_go;
   logic          mod_done;
   logic [NW-1:0] mod_rem;
   logic [LW-1:0] blen [BUCKETS];
   logic [7:0]    bkey [BUCKETS*(2**KW)];
   logic [VW-1:0] bval [BUCKETS];
   logic [7:0]    kd_ff, kb_ff;
   logic [LW-1:0] bl_ff;
   logic [VW-1:0] bv_ff;
   logic          wr_en;
   logic [BW-1:0] nb;
   logic          acc;

   assign acc = start && !busy;
   assign nb = ({1'b0, b_ff} + 1'b1 == (BW+1)'(n_ff)) ? '0 : b_ff + 1'b1;

   oaht_mod #(.DW(32), .NW(NW)) u_mod (
      .clock(clock), .reset(reset), .start(mod_go), .dividend(hash_ff),
      .divisor(n_ff), .done(mod_done), .remainder(mod_rem)
   );

   // Sequencer
   always_comb begin
      state_in = state_ff; klen_in = klen_ff; kov_in = kov_ff; hash_in = hash_ff;
      fin_in = fin_ff; cmd_in = cmd_ff; val_in = val_ff; used_in = used_ff;
      cnt_in = cnt_ff; n_in = n_ff; b_in = b_ff; start_b_in = start_b_ff;
      k_in = k_ff; j_in = j_ff; st_in = st_ff; fv_in = fv_ff; rv_in = 1'b0;
      mod_go = 1'b0; wr_en = 1'b0;
      unique case (state_ff)
         S_IDLE: if (acc) begin
            if (klen_ff < LW'(MAX_KEY_BYTES)) begin
               klen_in = klen_ff + 1'b1;
               hash_in = oat_byte(hash_ff, req_key_byte);
            end else kov_in = 1'b1;
            if (req_key_last) begin
               cmd_in = req_cmd; val_in = req_value[VW-1:0]; fin_in = '0;
               n_in = (bcnt_ff == 7'd0) ? NW'(1) :
                      ({25'd0, bcnt_ff} > BUCKETS) ? NW'(BUCKETS) : NW'(bcnt_ff);
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            // finish hash one shift-add or shift-xor step per cycle
            unique case (fin_ff)
               2'd0: hash_in = hash_ff + (hash_ff << 3);
               2'd1: hash_in = hash_ff ^ (hash_ff >> 11);
               default: hash_in = hash_ff + (hash_ff << 15);
            endcase
            fin_in = fin_ff + 1'b1;
            if (fin_ff == 2'd2) state_in = S_FINW;
         end
         S_FINW: begin
            mod_go = 1'b1; state_in = S_MOD;
         end
         S_MOD: if (mod_done) begin
            b_in = mod_rem[BW-1:0]; start_b_in = mod_rem[BW-1:0]; k_in = '0;
            st_in = ST_OK; fv_in = '0;
            if (kov_ff) begin st_in = ST_TOO_LONG; state_in = S_DONE; end
            else if (cmd_ff == CMD_INSERT && val_ff == '0) begin
               st_in = ST_ZERO_VALUE; state_in = S_DONE;
            end else state_in = S_CHK;
         end
         S_CHK: begin
            // probe one bucket for the key
            if (k_ff == n_ff) begin
               if (cmd_ff == CMD_INSERT) begin
                  b_in = start_b_ff; k_in = '0; state_in = S_FREE;
               end else begin st_in = ST_NOT_FOUND; state_in = S_DONE; end
            end else if (used_ff[b_ff] && bl_ff == klen_ff && klen_ff != '0) begin
               j_in = '0; state_in = S_RD;
            end else if (used_ff[b_ff] && klen_ff == '0 && bl_ff == '0) begin
               state_in = S_CMP; j_in = '0;
            end else begin b_in = nb; k_in = k_ff + 1'b1; end
         end
         S_RD: state_in = S_CMP;
         S_CMP: begin
            if (klen_ff == '0 || (kd_ff == kb_ff && {1'b0, j_ff} + 1'b1 == klen_ff)) begin
               // matched
               unique case (cmd_ff)
                  CMD_INSERT: st_in = ST_DUPLICATE;
                  CMD_REMOVE: begin
                     used_in[b_ff] = 1'b0;
                     if (cnt_ff != '0) cnt_in = cnt_ff - 1'b1;
                  end
                  default: fv_in = 32'(bv_ff);
               endcase
               state_in = S_DONE;
            end else if (kd_ff == kb_ff) begin
               j_in = j_ff + 1'b1; state_in = S_RD;
            end else begin
               b_in = nb; k_in = k_ff + 1'b1; state_in = S_CHK;
            end
         end
         S_FREE: begin
            if (k_ff == n_ff) begin st_in = ST_FULL; state_in = S_DONE; end
            else if (!used_ff[b_ff]) begin
               // claim the bucket; the key copy runs while the result waits
               wr_en = 1'b1; used_in[b_ff] = 1'b1; cnt_in = cnt_ff + 1'b1;
               state_in = S_DONE;
            end else begin b_in = nb; k_in = k_ff + 1'b1; end
         end
         default: begin
            // S_DONE: emit result, restart key
            rv_in = 1'b1; klen_in = '0; kov_in = 1'b0; hash_in = '0; state_in = S_IDLE;
         end
      endcase
   end

   // Key buffer, bucket stores
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && acc && klen_ff < LW'(MAX_KEY_BYTES))
         kbuf[klen_ff[KW-1:0]] <= req_key_byte;
      if (wr_en) begin
         blen[b_ff] <= klen_ff;
         bval[b_ff] <= val_ff;
      end
      kd_ff <= kbuf[j_ff];
      kb_ff <= bkey[{b_ff, j_ff}];
      bl_ff <= blen[b_in];
      bv_ff <= bval[b_ff];
   end

   // Copy key bytes into the new bucket, one per cycle after allocation
   logic          cp_ff;
   logic [KW-1:0] cj_ff;
   logic [BW-1:0] cb_ff;
   always_ff @(posedge clock) begin
      if (reset) cp_ff <= 1'b0;
      else if (wr_en) begin cp_ff <= 1'b1; cj_ff <= '0; cb_ff <= b_ff; end
      else if (cp_ff) begin
         cj_ff <= cj_ff + 1'b1;
         if ({1'b0, cj_ff} + 1'b1 >= klen_ff) cp_ff <= 1'b0;
      end
      if (cp_ff && {1'b0, cj_ff} < klen_ff) bkey[{cb_ff, cj_ff}] <= kbuf[cj_ff];
   end

   always_ff @(posedge clock) begin
      fin_ff <= fin_in; cmd_ff <= cmd_in; val_ff <= val_in;
      n_ff <= n_in; b_ff <= b_in; start_b_ff <= start_b_in; k_ff <= k_in; j_ff <= j_in;
      st_ff <= st_in; fv_ff <= fv_in;
      if (reset) begin
         state_ff <= S_IDLE; klen_ff <= '0; kov_ff <= 1'b0; used_ff <= '0; cnt_ff <= '0;
         rv_ff <= 1'b0; bcnt_ff <= 7'd64; hash_ff <= '0;
      end else begin
         state_ff <= (cp_ff && state_in == S_IDLE && state_ff == S_DONE) ? S_DONE : state_in;
         if (!(cp_ff && state_ff == S_DONE)) begin
            klen_ff <= klen_in; kov_ff <= kov_in; rv_ff <= rv_in; hash_ff <= hash_in;
         end else begin
            rv_ff <= 1'b0;
         end
         used_ff <= used_in; cnt_ff <= cnt_in;
         if (csr_we) bcnt_ff <= csr_wdata;
      end
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rv_ff;
   assign rsp_status = st_ff;
   assign rsp_found_value = fv_ff;
   assign rsp_entry_count = 7'(cnt_ff);
endmodule

/* rtl/oaht_checker.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
module oaht_checker (
   input logic        clock,
   input logic        reset,
   input logic        busy,
   input logic        rsp_valid,
   input logic [2:0]  rsp_status,
   input logic [31:0] rsp_found_value
);
   import oaht_pkg::*;
   `CHK_IMPLY(a_rsp_busy, clock, reset, rsp_valid, !busy)
   `CHK_IMPLY(a_fv_ok, clock, reset, rsp_valid && rsp_status != ST_OK, rsp_found_value == 32'd0)
   `CHK_NEXT(a_rsp_idle, clock, reset, rsp_valid, !rsp_valid)
   `CHK_IMPLY(a_st_range, clock, reset, rsp_valid, rsp_status <= ST_ZERO_VALUE)
endmodule

bind open_addressing_hash_table_top oaht_checker u_chk (
   .clock(clock), .reset(reset), .busy(busy), .rsp_valid(rsp_valid),
   .rsp_status(rsp_status), .rsp_found_value(rsp_found_value)
);
